@@ sv/drcs_pkg.sv @@
package drcs_pkg;

    // Default build values for the chunk size and the buffer pool.
    localparam int CHUNK_BYTES_DEF  = 8192;
    localparam int BUFFER_COUNT_DEF = 32;

    // Chunk byte counts are 16-bit quantities throughout.
    localparam int CHUNK_W = 16;

    // Largest screen dimension the block handles.
    localparam logic [12:0] SCREEN_MAX = 13'd4096;

    // Configuration register reset values.
    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd600;
    localparam logic [7:0]  MAX_ROWS_RST      = 8'd16;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_MAX_ROWS      = 2'd2
    } cfg_index_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_CHUNK    = 3'd0,
        ST_BADRECT  = 3'd1,
        ST_TOOWIDE  = 3'd2,
        ST_LINKDOWN = 3'd3,
        ST_DROP     = 3'd4
    } status_t;

endpackage

@@ sv/drcs_div.sv @@
module drcs_div
    import drcs_pkg::*;
#(
    parameter int DIVIDEND_W = CHUNK_W,
    parameter int DIVISOR_W  = 14
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    // Remainder, quotient shift register and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dsr_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // Done pulses for one cycle after the last step.
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/dirty_rect_chunk_splitter_core.sv @@
// A rejected rectangle moves to the reject state, then loads its result beat when the output is free.
// A valid rectangle runs a bit-serial division of the chunk size by the row byte count,
// then a clamp and a setup step; its first band follows from the band state and further
// bands come one per cycle while the output is free.
// The input stalls until a rectangle's last beat is loaded, so one rectangle is in work at a time.
// Reset: asynchronous, active low; registers return to 1024, 600 and 16, drop count to zero.
module dirty_rect_chunk_splitter_core
    import drcs_pkg::*;
#(
    parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF,
    parameter int BUFFER_COUNT = BUFFER_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] left,
    input  logic signed [15:0] top,
    input  logic signed [15:0] right,
    input  logic signed [15:0] bottom,
    input  logic               link_up,
    input  logic [5:0]         free_buffers,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [11:0]        origin_x,
    output logic [11:0]        origin_y,
    output logic [12:0]        rect_width,
    output logic [12:0]        rect_height,
    output logic [11:0]        band_row,
    output logic [7:0]         band_rows,
    output logic [15:0]        band_bytes,
    output logic [24:0]        source_offset,
    output logic               last,
    output logic [31:0]        drops_total
);

    localparam logic [CHUNK_W-1:0] CHUNK_LIMIT = CHUNK_W'(CHUNK_BYTES);
    localparam logic [5:0]         BUF_LIMIT   = 6'(BUFFER_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REJECT,
        S_DIV,
        S_PREP,
        S_BAND
    } state_t;

    // Configuration registers.
    logic [12:0] scr_w_reg;
    logic [12:0] scr_h_reg;
    logic [7:0]  max_rows_reg;

    // Sequencer state and per-rectangle working registers.
    state_t      state_reg;
    status_t     rej_reg;
    logic [11:0] ox_reg;
    logic [11:0] oy_reg;
    logic [12:0] w_reg;
    logic [12:0] h_reg;
    logic [5:0]  free_reg;
    logic [7:0]  maxrows_reg;
    logic [12:0] row_reg;
    logic [12:0] remain_reg;
    logic [24:0] offset_reg;
    logic [15:0] full_bytes_reg;
    logic [31:0] drop_cnt_reg;

    // Output register.
    logic        out_valid_reg;
    status_t     status_reg;
    logic [11:0] ox_out_reg;
    logic [11:0] oy_out_reg;
    logic [12:0] w_out_reg;
    logic [12:0] h_out_reg;
    logic [11:0] brow_out_reg;
    logic [7:0]  brows_out_reg;
    logic [15:0] bbytes_out_reg;
    logic [24:0] offset_out_reg;
    logic        last_out_reg;

    logic               in_beat;
    logic               out_free;
    logic               out_load;
    logic [12:0]        scr_w;
    logic [12:0]        scr_h;
    logic [7:0]         cap;
    logic signed [16:0] scr_w_s;
    logic signed [16:0] scr_h_s;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [12:0]        w_calc;
    logic [12:0]        h_calc;
    logic               bad_rect;
    logic               too_wide;
    logic [5:0]         free_clamped;
    logic               div_done;
    logic [CHUNK_W-1:0] div_quo;
    logic [CHUNK_W-1:0] cap_ext;
    logic               final_band;
    logic [7:0]         rows_sel;
    logic [7:0]         mul_rows;
    logic [20:0]        prod;
    logic [15:0]        bytes_calc;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg    <= SCREEN_WIDTH_RST;
            scr_h_reg    <= SCREEN_HEIGHT_RST;
            max_rows_reg <= MAX_ROWS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCREEN_WIDTH:  scr_w_reg    <= cfg_data;
                CFG_SCREEN_HEIGHT: scr_h_reg    <= cfg_data;
                CFG_MAX_ROWS:      max_rows_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Effective limits after clamping.
    assign scr_w   = (scr_w_reg > SCREEN_MAX) ? SCREEN_MAX : scr_w_reg;
    assign scr_h   = (scr_h_reg > SCREEN_MAX) ? SCREEN_MAX : scr_h_reg;
    assign cap     = (max_rows_reg == 8'd0) ? 8'd1 : max_rows_reg;
    assign scr_w_s = $signed({4'b0000, scr_w});
    assign scr_h_s = $signed({4'b0000, scr_h});

    // Rectangle checks on the incoming beat.
    assign dx       = right - left;
    assign dy       = bottom - top;
    assign w_calc   = dx[12:0] + 13'd1;
    assign h_calc   = dy[12:0] + 13'd1;
    assign bad_rect = (left < 0) || (top < 0) || (right >= scr_w_s) ||
                      (bottom >= scr_h_s) || (right < left) || (bottom < top);
    assign too_wide = ({3'b000, w_calc, 1'b0} > {1'b0, CHUNK_LIMIT});
    assign free_clamped = (free_buffers > BUF_LIMIT) ? BUF_LIMIT : free_buffers;

    assign in_stall = (state_reg != S_IDLE);
    assign in_beat  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_REJECT) || (state_reg == S_BAND));

    // Rows per band come from the chunk size divided by the row byte count.
    drcs_div #(
        .DIVIDEND_W (CHUNK_W),
        .DIVISOR_W  (14)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_beat && link_up && !bad_rect && !too_wide),
        .dividend (CHUNK_LIMIT),
        .divisor  ({w_calc, 1'b0}),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cap_ext = CHUNK_W'(cap);

    // Band size and byte count; the setup cycle uses the multiplier for a full band.
    assign final_band = (remain_reg <= {5'b00000, maxrows_reg});
    assign rows_sel   = final_band ? remain_reg[7:0] : maxrows_reg;
    assign mul_rows   = (state_reg == S_BAND) ? rows_sel : maxrows_reg;
    assign prod       = {8'd0, w_reg} * {13'd0, mul_rows};
    assign bytes_calc = {prod[14:0], 1'b0};

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rej_reg        <= ST_CHUNK;
            ox_reg         <= '0;
            oy_reg         <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            free_reg       <= '0;
            maxrows_reg    <= '0;
            row_reg        <= '0;
            remain_reg     <= '0;
            offset_reg     <= '0;
            full_bytes_reg <= '0;
            drop_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_CHUNK;
            ox_out_reg     <= '0;
            oy_out_reg     <= '0;
            w_out_reg      <= '0;
            h_out_reg      <= '0;
            brow_out_reg   <= '0;
            brows_out_reg  <= '0;
            bbytes_out_reg <= '0;
            offset_out_reg <= '0;
            last_out_reg   <= 1'b0;
        end
        else
        begin
            // The output register fills on a load and empties when its beat is taken.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        ox_reg   <= left[11:0];
                        oy_reg   <= top[11:0];
                        w_reg    <= w_calc;
                        h_reg    <= h_calc;
                        free_reg <= free_clamped;
                        priority if (!link_up)
                        begin
                            rej_reg   <= ST_LINKDOWN;
                            state_reg <= S_REJECT;
                        end
                        else if (bad_rect)
                        begin
                            rej_reg   <= ST_BADRECT;
                            state_reg <= S_REJECT;
                        end
                        else if (too_wide)
                        begin
                            rej_reg   <= ST_TOOWIDE;
                            state_reg <= S_REJECT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_REJECT:
                begin
                    if (out_free)
                    begin
                        status_reg     <= rej_reg;
                        ox_out_reg     <= '0;
                        oy_out_reg     <= '0;
                        w_out_reg      <= '0;
                        h_out_reg      <= '0;
                        brow_out_reg   <= '0;
                        brows_out_reg  <= '0;
                        bbytes_out_reg <= '0;
                        offset_out_reg <= '0;
                        last_out_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        maxrows_reg <= (div_quo > cap_ext) ? cap : div_quo[7:0];
                        state_reg   <= S_PREP;
                    end
                end

                S_PREP:
                begin
                    full_bytes_reg <= bytes_calc;
                    row_reg        <= '0;
                    remain_reg     <= h_reg;
                    offset_reg     <= '0;
                    state_reg      <= S_BAND;
                end

                S_BAND:
                begin
                    if (out_free)
                    begin
                        ox_out_reg    <= ox_reg;
                        oy_out_reg    <= oy_reg;
                        w_out_reg     <= w_reg;
                        h_out_reg     <= h_reg;
                        brow_out_reg  <= row_reg[11:0];
                        if (free_reg == 6'd0)
                        begin
                            // Out of buffers: the drop beat ends this rectangle.
                            status_reg     <= ST_DROP;
                            brows_out_reg  <= '0;
                            bbytes_out_reg <= '0;
                            offset_out_reg <= '0;
                            last_out_reg   <= 1'b1;
                            drop_cnt_reg   <= drop_cnt_reg + 32'd1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            status_reg     <= ST_CHUNK;
                            brows_out_reg  <= rows_sel;
                            bbytes_out_reg <= bytes_calc;
                            offset_out_reg <= offset_reg;
                            last_out_reg   <= final_band;
                            free_reg       <= free_reg - 6'd1;
                            row_reg        <= row_reg + {5'b00000, maxrows_reg};
                            remain_reg     <= remain_reg - {5'b00000, maxrows_reg};
                            offset_reg     <= offset_reg + {9'd0, full_bytes_reg};
                            if (final_band)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The drop count only moves when a drop beat is loaded, so it matches the shown beat.
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign origin_x      = ox_out_reg;
    assign origin_y      = oy_out_reg;
    assign rect_width    = w_out_reg;
    assign rect_height   = h_out_reg;
    assign band_row      = brow_out_reg;
    assign band_rows     = brows_out_reg;
    assign band_bytes    = bbytes_out_reg;
    assign source_offset = offset_out_reg;
    assign last          = last_out_reg;
    assign drops_total   = drop_cnt_reg;

endmodule

@@ bench/tb_dirty_rect_chunk_splitter_core.sv @@
module tb_dirty_rect_chunk_splitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import drcs_pkg::*;

    // Index beyond the register list; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int DIR_N          = 21;
    localparam int PHASES         = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic               link;
        logic [5:0]         freeb;
    } rect_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] ox;
        logic [11:0] oy;
        logic [12:0] w;
        logic [12:0] h;
        logic [11:0] brow;
        logic [7:0]  brows;
        logic [15:0] bbytes;
        logic [24:0] off;
        logic        last;
        logic [31:0] drops;
    } band_t;

    typedef struct {
        rect_t   r;
        bit      typed;
        status_t st;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [12:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] left = '0;
    logic signed [15:0] top = '0;
    logic signed [15:0] right = '0;
    logic signed [15:0] bottom = '0;
    logic               link_up = 1'b0;
    logic [5:0]         free_buffers = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic [11:0]        origin_x;
    logic [11:0]        origin_y;
    logic [12:0]        rect_width;
    logic [12:0]        rect_height;
    logic [11:0]        band_row;
    logic [7:0]         band_rows;
    logic [15:0]        band_bytes;
    logic [24:0]        source_offset;
    logic               last;
    logic [31:0]        drops_total;

    // Local copy of the block's registers and drop count.
    logic [12:0] scr_w = SCREEN_WIDTH_RST;
    logic [12:0] scr_h = SCREEN_HEIGHT_RST;
    logic [7:0]  max_rows = MAX_ROWS_RST;
    logic [31:0] drop_count = '0;

    band_t pending_bands [$];
    int    fail_count = 0;
    int    idle_cycles = 0;
    int    press_req = 0;
    int    press_seen = 0;
    int    hold_left = 0;
    int    burst_left = 0;
    band_t got;
    band_t want_now;

    // Directed rectangles, run with the reset register values.
    dir_row_t dir_tab [DIR_N] = '{
        '{'{0, 0, 9, 9, 1'b0, 6'd5}, 1'b1, ST_LINKDOWN},
        '{'{-32768, -32768, -32768, -32768, 1'b0, 6'd0}, 1'b1, ST_LINKDOWN},
        '{'{-1, 0, 9, 9, 1'b1, 6'd5}, 1'b1, ST_BADRECT},
        '{'{0, -1, 9, 9, 1'b1, 6'd5}, 1'b1, ST_BADRECT},
        '{'{0, 0, 1024, 9, 1'b1, 6'd5}, 1'b1, ST_BADRECT},
        '{'{0, 0, 9, 600, 1'b1, 6'd5}, 1'b1, ST_BADRECT},
        '{'{5, 0, 4, 0, 1'b1, 6'd5}, 1'b1, ST_BADRECT},
        '{'{0, 5, 0, 4, 1'b1, 6'd5}, 1'b1, ST_BADRECT},
        '{'{32767, 32767, 32767, 32767, 1'b1, 6'd63}, 1'b1, ST_BADRECT},
        '{'{-32768, -32768, 32767, 32767, 1'b1, 6'd63}, 1'b1, ST_BADRECT},
        '{'{0, 0, 0, 0, 1'b1, 6'd1}, 1'b0, ST_CHUNK},
        '{'{1023, 599, 1023, 599, 1'b1, 6'd1}, 1'b0, ST_CHUNK},
        '{'{10, 20, 137, 83, 1'b1, 6'd5}, 1'b0, ST_CHUNK},
        '{'{0, 0, 127, 63, 1'b1, 6'd4}, 1'b0, ST_CHUNK},
        '{'{0, 0, 127, 63, 1'b1, 6'd3}, 1'b0, ST_CHUNK},
        '{'{0, 0, 511, 20, 1'b1, 6'd10}, 1'b0, ST_CHUNK},
        '{'{0, 0, 1023, 599, 1'b1, 6'd32}, 1'b0, ST_CHUNK},
        '{'{0, 0, 1023, 199, 1'b1, 6'd63}, 1'b0, ST_CHUNK},
        '{'{3, 4, 3, 4, 1'b1, 6'd0}, 1'b0, ST_CHUNK},
        '{'{0, 0, 0, 599, 1'b1, 6'd32}, 1'b0, ST_CHUNK},
        '{'{100, 100, 1023, 599, 1'b1, 6'd0}, 1'b0, ST_CHUNK}
    };

    dirty_rect_chunk_splitter_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left          (left),
        .top           (top),
        .right         (right),
        .bottom        (bottom),
        .link_up       (link_up),
        .free_buffers  (free_buffers),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .band_row      (band_row),
        .band_rows     (band_rows),
        .band_bytes    (band_bytes),
        .source_offset (source_offset),
        .last          (last),
        .drops_total   (drops_total)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Works out the beats that one rectangle should produce and queues them.
    function automatic void split_rect(rect_t r);
        int    x1, y1, x2, y2, sw, sh, cap, w, h, per_band, freeb, row, rows;
        band_t b;
        x1 = r.left;
        y1 = r.top;
        x2 = r.right;
        y2 = r.bottom;
        sw = (scr_w > SCREEN_MAX) ? SCREEN_MAX : scr_w;
        sh = (scr_h > SCREEN_MAX) ? SCREEN_MAX : scr_h;
        cap = (max_rows == 0) ? 1 : max_rows;
        b = '0;
        b.last = 1'b1;
        b.drops = drop_count;
        if (!r.link)
        begin
            b.status = ST_LINKDOWN;
            pending_bands.push_back(b);
            return;
        end
        if (x1 < 0 || y1 < 0 || x2 >= sw || y2 >= sh || x2 < x1 || y2 < y1)
        begin
            b.status = ST_BADRECT;
            pending_bands.push_back(b);
            return;
        end
        w = x2 - x1 + 1;
        h = y2 - y1 + 1;
        per_band = CHUNK_BYTES_DEF / (w * 2);
        if (per_band == 0)
        begin
            b.status = ST_TOOWIDE;
            pending_bands.push_back(b);
            return;
        end
        if (per_band > cap)
            per_band = cap;
        freeb = (r.freeb > BUFFER_COUNT_DEF) ? BUFFER_COUNT_DEF : r.freeb;
        b.ox = 12'(x1);
        b.oy = 12'(y1);
        b.w = 13'(w);
        b.h = 13'(h);
        // One band per free buffer; running out ends the rectangle with a drop.
        for (row = 0; row < h; row += per_band)
        begin
            rows = (row + per_band <= h) ? per_band : h - row;
            b.brow = 12'(row);
            if (freeb == 0)
            begin
                drop_count = drop_count + 32'd1;
                b.status = ST_DROP;
                b.brows = '0;
                b.bbytes = '0;
                b.off = '0;
                b.last = 1'b1;
                b.drops = drop_count;
                pending_bands.push_back(b);
                return;
            end
            freeb--;
            b.status = ST_CHUNK;
            b.brows = 8'(rows);
            b.bbytes = 16'(w * rows * 2);
            b.off = 25'(row * w * 2);
            b.last = (row + rows >= h);
            pending_bands.push_back(b);
        end
    endfunction

    function automatic string band_str(band_t b);
        return $sformatf({"st=%0d x=%0d y=%0d w=%0d h=%0d row=%0d rows=%0d",
                          " bytes=%0d off=%0d last=%0d drops=%0d"},
                         b.status, b.ox, b.oy, b.w, b.h, b.brow, b.brows, b.bbytes,
                         b.off, b.last, b.drops);
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        else if (p < 80)
            return $urandom_range(1, 3);
        else if (p < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 90);
    endfunction

    // Span along one axis, biased towards small rectangles.
    function automatic int pick_span(int lim);
        int p;
        p = $urandom_range(0, 9);
        if (p < 6)
            return $urandom_range(1, (lim < 16) ? lim : 16);
        else if (p < 9)
            return $urandom_range(1, lim);
        else
            return lim;
    endfunction

    // Mostly rectangles on the current screen; some raw noise and off-by-one edges.
    function automatic rect_t make_rect();
        rect_t r;
        int    sw, sh, w, h, p, q;
        sw = (scr_w > SCREEN_MAX) ? SCREEN_MAX : scr_w;
        sh = (scr_h > SCREEN_MAX) ? SCREEN_MAX : scr_h;
        p = $urandom_range(0, 99);
        if (p < 15 || sw == 0 || sh == 0)
        begin
            r.left = 16'($urandom);
            r.top = 16'($urandom);
            r.right = 16'($urandom);
            r.bottom = 16'($urandom);
            r.link = 1'($urandom);
            r.freeb = 6'($urandom);
            return r;
        end
        w = pick_span(sw);
        h = pick_span(sh);
        r.left = 16'($urandom_range(0, sw - w));
        r.top = 16'($urandom_range(0, sh - h));
        r.right = 16'(r.left + w - 1);
        r.bottom = 16'(r.top + h - 1);
        if (p < 22)
        begin
            if ($urandom_range(0, 1))
                r.right = 16'(sw);
            else
                r.bottom = 16'(sh);
        end
        r.link = ($urandom_range(0, 19) != 0);
        q = $urandom_range(0, 9);
        if (q < 5)
            r.freeb = 6'($urandom_range(0, 8));
        else if (q < 9)
            r.freeb = 6'($urandom_range(9, 32));
        else
            r.freeb = 6'($urandom_range(33, 63));
        return r;
    endfunction

    // Offers one rectangle and holds it until the block takes the beat.
    task automatic send_rect(rect_t r, int gap, bit typed, band_t want);
        in_valid <= 1'b1;
        left <= r.left;
        top <= r.top;
        right <= r.right;
        bottom <= r.bottom;
        link_up <= r.link;
        free_buffers <= r.freeb;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
            pending_bands.push_back(want);
        else
            split_rect(r);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  scr_w = val;
            CFG_SCREEN_HEIGHT: scr_h = val;
            CFG_MAX_ROWS:      max_rows = val[7:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    // Stops offering and lets every outstanding beat come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_bands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (press_seen != press_req)
        begin
            press_seen = press_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
        end
        else if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            burst_left = idle_len();
        end
    end

    // Compare each output beat with the oldest predicted band.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status_t'(status);
            got.ox = origin_x;
            got.oy = origin_y;
            got.w = rect_width;
            got.h = rect_height;
            got.brow = band_row;
            got.brows = band_rows;
            got.bbytes = band_bytes;
            got.off = source_offset;
            got.last = last;
            got.drops = drops_total;
            if (pending_bands.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("%0t: unexpected beat %s", $realtime, band_str(got));
            end
            else
            begin
                want_now = pending_bands.pop_front();
                if (got !== want_now)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                    begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected %s", band_str(want_now));
                        $display("  actual   %s", band_str(got));
                    end
                end
            end
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: directed table, then phases of random rectangles per register setting.
    initial
    begin
        int          i, p, n;
        band_t       want;
        logic [12:0] sw_val, sh_val, rows_val;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            want = '0;
            want.status = dir_tab[i].st;
            want.last = 1'b1;
            send_rect(dir_tab[i].r, idle_len(), dir_tab[i].typed, want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    sw_val = 13'd4096;
                    sh_val = 13'd4096;
                    rows_val = 13'd255;
                    n = 50;
                end
                1:
                begin
                    sw_val = 13'd1;
                    sh_val = 13'd1;
                    rows_val = 13'd1;
                    n = 25;
                end
                2:
                begin
                    // Sizes above the maximum clamp; the row limit keeps only its low byte, which is zero.
                    sw_val = 13'd8191;
                    sh_val = 13'd5000;
                    rows_val = 13'h1F00;
                    n = 40;
                end
                3:
                begin
                    // A zero-sized screen rejects everything.
                    sw_val = 13'd0;
                    sh_val = 13'd0;
                    rows_val = 13'd16;
                    n = 15;
                end
                default:
                begin
                    sw_val = 13'($urandom_range(1, 4096));
                    sh_val = 13'($urandom_range(1, 4096));
                    rows_val = 13'($urandom_range(1, 255));
                    n = 45;
                end
            endcase
            write_reg(CFG_SCREEN_WIDTH, sw_val);
            write_reg(CFG_SCREEN_HEIGHT, sh_val);
            write_reg(CFG_MAX_ROWS, rows_val);
            write_reg(CFG_UNUSED, 13'($urandom));
            // First phase: long receiver hold-off while the sender keeps offering.
            if (p == 0)
                press_req <= press_req + 1;
            for (i = 0; i < n; i++)
                send_rect(make_rect(), (p == 0) ? 0 : idle_len(), 1'b0, want);
        end

        in_valid <= 1'b0;
        while (pending_bands.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
